>>> sv/icrc_pkg.sv
// shared types, constants and crc step functions for the image crc16 verifier
package icrc_pkg;

  localparam int unsigned CrcWidth  = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned NumLanes  = 4;
  localparam int unsigned WordWidth = NumLanes * ByteWidth;
  localparam int unsigned AdvWidth  = $clog2(NumLanes);

  localparam logic [CrcWidth-1:0] CrcPoly = 16'h1021;

  typedef logic [CrcWidth-1:0]  crc_t;
  typedef logic [ByteWidth-1:0] byte_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  // augmented crc: data bits enter at bit 0, msb of the byte first
  function automatic crc_t feed_byte(crc_t crc, byte_t data);
    crc_t c;
    logic top;
    c = crc;
    for (int i = 0; i < ByteWidth; i++) begin
      top = c[CrcWidth-1];
      c   = {c[CrcWidth-2:0], data[ByteWidth-1-i]};
      if (top) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic crc_t zero_byte(crc_t crc);
    return feed_byte(crc, '0);
  endfunction

endpackage

>>> sv/image_crc16_verifier.sv
// top level: four byte lanes and a merge stage computing the augmented crc16 of an image
// a final beat is registered in the lanes, then its result in the merge stage; a stalled result can hold it between
// throughput: one 32-bit word per cycle while the input is not stalled; four byte lanes are combined in the merge stage
// the running crc loop closes through the single crc register of the merge stage over the advanced crc
// input stalls only while a final beat waits behind a result that is itself stalled
// reset clears the running crc, the expected crc and all valid flags
module image_crc16_verifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [icrc_pkg::CrcWidth-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [icrc_pkg::WordWidth-1:0]     image_word_i,
  input  logic                               final_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [icrc_pkg::CrcWidth-1:0]      computed_crc_o,
  output logic                               crc_matches_o
);

  icrc_pkg::crc_t       expected_q;
  icrc_pkg::stage_ctl_t ctl_d, ctl_q;
  icrc_pkg::crc_t       contrib [icrc_pkg::NumLanes];
  logic                 hold;
  logic                 lane_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= '0;
    end else if (cfg_we_i) begin
      expected_q <= cfg_wdata_i;
    end
  end

  assign lane_en = in_valid_i & ~hold;

  always_comb begin
    ctl_d = ctl_q;
    if (!hold) begin
      ctl_d.valid = in_valid_i;
      ctl_d.last  = final_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  for (genvar k = 0; k < icrc_pkg::NumLanes; k++) begin : g_lane
    icrc_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (lane_en),
      .data_i    (image_word_i[k*icrc_pkg::ByteWidth +: icrc_pkg::ByteWidth]),
      .adv_i     (icrc_pkg::AdvWidth'(icrc_pkg::NumLanes - 1 - k)),
      .contrib_o (contrib[k])
    );
  end

  icrc_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl_q),
    .contrib_i      (contrib),
    .expected_i     (expected_q),
    .out_stall_i    (out_stall_i),
    .hold_o         (hold),
    .out_valid_o    (out_valid_o),
    .computed_crc_o (computed_crc_o),
    .crc_matches_o  (crc_matches_o)
  );

  assign in_stall_o = hold;

endmodule

>>> sv/icrc_lane.sv
// one byte lane: crc contribution of its byte, advanced over the later bytes of the beat
module icrc_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  icrc_pkg::byte_t             data_i,
  input  logic [icrc_pkg::AdvWidth-1:0] adv_i,
  output icrc_pkg::crc_t              contrib_o
);

  icrc_pkg::crc_t contrib_d, contrib_q;

  always_comb begin
    contrib_d = icrc_pkg::feed_byte('0, data_i);
    for (int j = 0; j < icrc_pkg::NumLanes - 1; j++) begin
      if (icrc_pkg::AdvWidth'(j) < adv_i) begin
        contrib_d = icrc_pkg::zero_byte(contrib_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrib_q <= '0;
    end else if (en_i) begin
      contrib_q <= contrib_d;
    end
  end

  assign contrib_o = contrib_q;

endmodule

>>> sv/icrc_merge.sv
// merge stage: combines lane contributions with the running crc and holds the result
module icrc_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  icrc_pkg::stage_ctl_t ctl_i,
  input  icrc_pkg::crc_t       contrib_i [icrc_pkg::NumLanes],
  input  icrc_pkg::crc_t       expected_i,
  input  logic                 out_stall_i,
  output logic                 hold_o,
  output logic                 out_valid_o,
  output icrc_pkg::crc_t       computed_crc_o,
  output logic                 crc_matches_o
);

  icrc_pkg::crc_t crc_d, crc_q;
  icrc_pkg::crc_t res_d, res_q;
  logic           match_d, match_q;
  logic           out_valid_d, out_valid_q;
  icrc_pkg::crc_t data_x, crc_adv, crc_new, crc_fin;
  logic           hold, fire;

  assign hold = ctl_i.valid & ctl_i.last & out_valid_q & out_stall_i;
  assign fire = ctl_i.valid & ~hold;

  always_comb begin
    data_x = '0;
    for (int k = 0; k < icrc_pkg::NumLanes; k++) begin
      data_x = data_x ^ contrib_i[k];
    end
    crc_adv = crc_q;
    for (int k = 0; k < icrc_pkg::NumLanes; k++) begin
      crc_adv = icrc_pkg::zero_byte(crc_adv);
    end
    crc_new = crc_adv ^ data_x;
    // two zero bytes of augmentation
    crc_fin = icrc_pkg::zero_byte(icrc_pkg::zero_byte(crc_new));

    crc_d       = crc_q;
    res_d       = res_q;
    match_d     = match_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (fire) begin
      if (ctl_i.last) begin
        crc_d       = '0;
        res_d       = crc_fin;
        match_d     = (crc_fin == expected_i);
        out_valid_d = 1'b1;
      end else begin
        crc_d = crc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    match_q <= match_d;
  end

  assign hold_o         = hold;
  assign out_valid_o    = out_valid_q;
  assign computed_crc_o = res_q;
  assign crc_matches_o  = match_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && ctl_i.last |=> out_valid_q)
    else $error("final beat did not produce a result");

  a_last_clears_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && ctl_i.last |=> crc_q == '0)
    else $error("running crc not cleared after final beat");

  a_hold_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |-> out_valid_q && ctl_i.valid)
    else $error("merge stage held without a pending result");

  a_result_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !(fire && ctl_i.last) |=> !out_valid_q)
    else $error("result repeated after it was taken");

endmodule

>>> sim/tb.sv
// testbench for image_crc16_verifier: streamed images checked against a bitwise crc16 predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TargetBeats = 850;
  localparam int unsigned ReportLimit = 10;

  typedef icrc_pkg::crc_t crc_t;
  typedef logic [icrc_pkg::WordWidth-1:0] word_t;

  typedef struct packed {
    word_t data;
    logic  last;
  } beat_t;

  typedef struct packed {
    crc_t crc;
    logic match;
  } crc_result_t;

  logic  clk_i        = 1'b0;
  logic  rst_ni       = 1'b0;
  logic  cfg_we_i     = 1'b0;
  crc_t  cfg_wdata_i  = '0;
  logic  in_valid_i   = 1'b0;
  word_t image_word_i = '0;
  logic  final_word_i = 1'b0;
  logic  out_stall_i  = 1'b0;
  logic  in_stall_o;
  logic  out_valid_o;
  crc_t  computed_crc_o;
  logic  crc_matches_o;

  beat_t       staged_beats[$];
  beat_t       image_beats[$];
  crc_result_t awaited_crcs[$];

  crc_t        image_crc   = '0;
  crc_t        stored_crc  = '0;
  bit          steady      = 1'b0;
  int unsigned send_gap    = 0;
  int unsigned rx_gap      = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_asks   = 0;
  int unsigned hold_served = 0;
  int unsigned beats_total = 0;
  int unsigned fail_count  = 0;

  image_crc16_verifier dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .image_word_i   (image_word_i),
    .final_word_i   (final_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .computed_crc_o (computed_crc_o),
    .crc_matches_o  (crc_matches_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic crc_t crc_shift_in(crc_t c, logic d);
    crc_t s;
    s = {c[icrc_pkg::CrcWidth-2:0], d};
    if (c[icrc_pkg::CrcWidth-1]) begin
      s = s ^ icrc_pkg::CrcPoly;
    end
    return s;
  endfunction

  // lane 0 first, msb of each byte first
  function automatic crc_t crc_absorb_word(crc_t c, word_t w);
    crc_t s;
    s = c;
    for (int k = 0; k < icrc_pkg::NumLanes; k++) begin
      for (int b = icrc_pkg::ByteWidth - 1; b >= 0; b--) begin
        s = crc_shift_in(s, w[k*icrc_pkg::ByteWidth+b]);
      end
    end
    return s;
  endfunction

  // augmentation: two zero bytes
  function automatic crc_t crc_close(crc_t c);
    crc_t s;
    s = c;
    for (int i = 0; i < 2 * icrc_pkg::ByteWidth; i++) begin
      s = crc_shift_in(s, 1'b0);
    end
    return s;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic word_t rand_word();
    int unsigned r;
    word_t w;
    r = $urandom_range(9);
    w = $urandom;
    if (r == 0) w = '0;
    else if (r == 1) w = '1;
    else if (r == 2) begin
      w = word_t'($urandom_range(255)) << (icrc_pkg::ByteWidth * $urandom_range(3));
    end
    return w;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= ReportLimit) $display("%0t: %s", $time, msg);
  endtask

  task automatic stage_beat(input word_t data, input logic last);
    beat_t b;
    b.data = data;
    b.last = last;
    staged_beats.push_back(b);
    beats_total++;
  endtask

  task automatic stage_image(input int unsigned len, output crc_t crc);
    crc_t  c;
    word_t w;
    c = '0;
    for (int unsigned i = 0; i < len; i++) begin
      w = rand_word();
      c = crc_absorb_word(c, w);
      stage_beat(w, i == len - 1);
    end
    crc = crc_close(c);
  endtask

  task automatic write_expected(input crc_t value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    stored_crc  = value;
  endtask

  task automatic wait_idle();
    while (image_beats.size() != 0 || in_valid_i || awaited_crcs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // optional register write, then release the staged beats and drain
  task automatic run_phase(input bit write_cfg, input crc_t value);
    if (write_cfg) write_expected(value);
    while (staged_beats.size() != 0) image_beats.push_back(staged_beats.pop_front());
    wait_idle();
  endtask

  always @(posedge clk_i) begin : driver
    crc_t        c;
    crc_result_t res;
    beat_t       nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        c = crc_absorb_word(image_crc, image_word_i);
        if (final_word_i) begin
          c         = crc_close(c);
          res.crc   = c;
          res.match = (c == stored_crc);
          awaited_crcs.push_back(res);
          image_crc = '0;
        end else begin
          image_crc = c;
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (image_beats.size() != 0) begin
          nxt          = image_beats.pop_front();
          image_word_i <= nxt.data;
          final_word_i <= nxt.last;
          in_valid_i   <= 1'b1;
          send_gap     = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : hold_off
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_served) begin
      hold_left   <= HoldCycles;
      hold_served <= hold_served + 1;
    end
  end

  always @(posedge clk_i) begin : monitor
    crc_result_t want;
    logic        stall_n;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_crcs.size() == 0) begin
        note_failure($sformatf("unexpected result beat: crc %h match %b",
                               computed_crc_o, crc_matches_o));
      end else begin
        want = awaited_crcs.pop_front();
        if (computed_crc_o !== want.crc) begin
          note_failure($sformatf("computed_crc: expected %h, got %h", want.crc, computed_crc_o));
        end
        if (crc_matches_o !== want.match) begin
          note_failure($sformatf("crc_matches: expected %b, got %b (crc %h)",
                                 want.match, crc_matches_o, want.crc));
        end
      end
    end
    if (hold_left != 0) begin
      stall_n = 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap--;
      stall_n = 1'b1;
    end else begin
      rx_gap  = pick_gap();
      stall_n = (rx_gap != 0);
      if (stall_n) rx_gap--;
    end
    out_stall_i <= stall_n;
  end

  initial begin
    #10_000_000;
    $display("image_crc16_verifier regression: fail");
    $finish;
  end

  initial begin : stimulus
    crc_t        c;
    crc_t        first;
    crc_t        value;
    int unsigned r;
    int unsigned len;
    int unsigned n_img;
    int unsigned guard;
    bit          pressed;
    pressed = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero single word against the reset expectation
    stage_beat('0, 1'b1);
    run_phase(1'b0, '0);

    // extremes of the word, register at its top
    stage_beat('1, 1'b1);
    stage_beat(32'h0000_00ff, 1'b0);
    stage_beat(32'hff00_0000, 1'b0);
    stage_beat(32'h8000_0001, 1'b1);
    run_phase(1'b1, 16'hffff);

    // two-word image whose crc is the stored value
    c = crc_close(crc_absorb_word(crc_absorb_word('0, 32'h1234_5678), 32'hdead_beef));
    stage_beat(32'h1234_5678, 1'b0);
    stage_beat(32'hdead_beef, 1'b1);
    run_phase(1'b1, c);

    // register written while an image is open
    stage_beat(32'ha5a5_a5a5, 1'b0);
    run_phase(1'b1, '0);
    c = crc_close(crc_absorb_word(crc_absorb_word('0, 32'ha5a5_a5a5), 32'h5a5a_5a5a));
    stage_beat(32'h5a5a_5a5a, 1'b1);
    run_phase(1'b1, c);

    // walking bits, then back-to-back single-word images
    for (int i = 0; i < 6; i++) stage_beat(word_t'(1) << (6 * i + 1), i == 5);
    run_phase(1'b0, '0);
    steady = 1'b1;
    for (int i = 0; i < 4; i++) stage_image(1, c);
    run_phase(1'b0, '0);

    while (beats_total < TargetBeats) begin
      steady = ($urandom_range(3) == 0);
      n_img  = $urandom_range(6, 2);
      for (int unsigned j = 0; j < n_img; j++) begin
        r = $urandom_range(99);
        if (r < 70) len = $urandom_range(4, 1);
        else if (r < 95) len = $urandom_range(12, 5);
        else len = $urandom_range(40, 13);
        stage_image(len, c);
        if (j == 0) first = c;
      end
      r = $urandom_range(9);
      if (r < 3) value = first;
      else if (r == 3) value = '0;
      else if (r == 4) value = '1;
      else value = crc_t'($urandom);
      run_phase(r < 9, value);

      // long receiver hold-off while the sender keeps offering beats
      if (!pressed && beats_total > TargetBeats / 2) begin
        pressed = 1'b1;
        steady  = 1'b1;
        for (int i = 0; i < 80; i++) stage_beat(rand_word(), (i == 79) || ($urandom_range(1) == 1));
        @(negedge clk_i);
        hold_asks++;
        run_phase(1'b0, '0);
      end
    end

    guard = 0;
    while (awaited_crcs.size() != 0 && guard < 100_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (awaited_crcs.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", awaited_crcs.size()));
    end
    if (fail_count == 0) begin
      $display("image_crc16_verifier regression: pass");
    end else begin
      $display("image_crc16_verifier regression: fail");
    end
    $finish;
  end

endmodule

>>> image_crc16_verifier.f
sv/icrc_pkg.sv
sv/icrc_lane.sv
sv/icrc_merge.sv
sv/image_crc16_verifier.sv
sim/tb.sv
